FILE: rtl/core/hbe_pkg.sv
// shared types and constants for the histogram binning engine
package hbe_pkg;

    localparam int SAMPLE_W = 32;
    localparam int NB_W     = 11;
    localparam int IDX_W    = 10;
    localparam int OUT_CNT_W = 32;
    localparam int ERR_W    = 24;

    typedef enum logic [1:0] {
        KIND_COUNTED = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_READ    = 2'd2,
        KIND_BAD_BIN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_NUM_BINS  = 2'd0,
        CFG_LOW_EDGE  = 2'd1,
        CFG_HIGH_EDGE = 2'd2
    } cfg_idx_t;

endpackage

FILE: rtl/core/hbe_ram.sv
// generic single-port-write, one-read ram with registered read data
module hbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/hbe_div.sv
// restoring divider, one quotient bit per cycle
module hbe_div #(
    parameter int NW = 44,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] n_reg, n_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
            n_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: rtl/core/hbe_sqrt.sv
// bit-serial integer square root, one result bit per cycle
module hbe_sqrt #(
    parameter int VW = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [VW-1:0]   value,
    output logic            done,
    output logic [VW/2-1:0] root
);

    localparam int RW = VW / 2;
    localparam int CW = $clog2(RW + 1);

    logic [VW-1:0] v_reg, v_next;
    logic [RW+1:0] rem_reg, rem_next;
    logic [RW-1:0] q_reg, q_next;
    logic [CW-1:0] n_reg, n_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW+1:0] t_rem;
    logic [RW+1:0] t_sub;

    always_comb
    begin
        v_next = v_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        t_rem = {rem_reg[RW-1:0], v_reg[VW-1:VW-2]};
        t_sub = {q_reg, 2'b01};
        if (start)
        begin
            v_next = value;
            rem_next = '0;
            q_next = '0;
            n_next = CW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next = {v_reg[VW-3:0], 2'b00};
            if (t_rem >= t_sub)
            begin
                rem_next = t_rem - t_sub;
                q_next = {q_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next = t_rem;
                q_next = {q_reg[RW-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign root = q_reg;

endmodule

FILE: rtl/core/histogram_binning_engine.sv
// Histogram binning engine: equal-width bins over a signed Q16.16 range.
// A sample passes through the 44-step bin divider, then a count memory read and
// write back; a read passes through the count memory read and the square root;
// a dropped sample or a bad bin index gives its result in the next cycle.
// Items are handled one at a time; the next beat is taken the cycle after the result leaves.
// Reset: after rst_n a clearing pass writes zero to all MAX_BINS entries,
// during which no input beat is taken; registers get defaults.
module histogram_binning_engine #(
    parameter int MAX_BINS    = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic signed [31:0] sample,
    input  logic [9:0]  read_bin,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [9:0]  bin_index,
    output logic [31:0] count,
    output logic [23:0] count_error
);

    localparam int AW  = $clog2(MAX_BINS);
    localparam int NBW = $clog2(MAX_BINS + 1);
    localparam int NW  = 33 + NBW;
    localparam int SQW = 2 * ((COUNT_WIDTH + 17) / 2);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_RD    = 8'b0000_1000,
        ST_UPD   = 8'b0001_0000,
        ST_SQRT  = 8'b0010_0000,
        ST_SQWT  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [10:0]        nb_cfg_reg;
    logic signed [31:0] lo_reg, hi_reg;
    logic [AW:0]        clr_reg, clr_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic               act_reg, act_next;
    logic [1:0]         kind_reg, kind_next;
    logic [9:0]         idx_reg, idx_next;
    logic [31:0]        cnt_reg, cnt_next;
    logic [23:0]        err_reg, err_next;
    logic [COUNT_WIDTH-1:0] wcnt;

    logic [NBW-1:0] nb;
    logic [32:0]    off, range;
    logic           drop;
    logic [NW-1:0]  num;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

    logic           div_start, div_done;
    logic [NW-1:0]  quot;
    logic           sq_start, sq_done;
    logic [SQW/2-1:0] root;

    // bins in use, clamped at MAX_BINS
    always_comb
    begin
        if (32'(nb_cfg_reg) > 32'(MAX_BINS))
        begin
            nb = NBW'(MAX_BINS);
        end
        else
        begin
            nb = NBW'(nb_cfg_reg);
        end
    end

    assign off   = 33'($signed({sample[31], sample}) - $signed({lo_reg[31], lo_reg}));
    assign range = 33'($signed({hi_reg[31], hi_reg}) - $signed({lo_reg[31], lo_reg}));
    assign drop  = (nb == '0) || (sample < lo_reg) || (sample >= hi_reg);
    assign num   = NW'(off) * NW'(nb);

    hbe_div #(.NW(NW), .DW(33)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(num), .den(range),
        .done(div_done), .quot(quot)
    );

    hbe_sqrt #(.VW(SQW)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start),
        .value(SQW'({ram_rdata, 16'h0000})),
        .done(sq_done), .root(root)
    );

    hbe_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_BINS)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    assign wcnt = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        addr_next = addr_reg;
        act_next = act_reg;
        kind_next = kind_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        div_start = 1'b0;
        sq_start = 1'b0;
        ram_we = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = wcnt;
        ram_raddr = addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = clr_reg[AW-1:0];
                ram_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(MAX_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next = action;
                    idx_next = '0;
                    cnt_next = '0;
                    err_next = '0;
                    if (!action)
                    begin
                        if (drop)
                        begin
                            kind_next = hbe_pkg::KIND_DROPPED;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            div_start = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    else if (32'(read_bin) >= 32'(nb))
                    begin
                        kind_next = hbe_pkg::KIND_BAD_BIN;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        addr_next = AW'(read_bin);
                        state_next = ST_RD;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (quot >= NW'(nb))
                    begin
                        addr_next = AW'(nb - 1'b1);
                    end
                    else
                    begin
                        addr_next = AW'(quot);
                    end
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                // memory data arrives next cycle
                state_next = act_reg ? ST_SQRT : ST_UPD;
            end
            ST_UPD:
            begin
                ram_we = 1'b1;
                kind_next = hbe_pkg::KIND_COUNTED;
                idx_next = 10'(addr_reg);
                cnt_next = (COUNT_WIDTH > 32 && (wcnt >> 32) != '0) ? '1 : 32'(wcnt);
                state_next = ST_OUT;
            end
            ST_SQRT:
            begin
                sq_start = 1'b1;
                kind_next = hbe_pkg::KIND_READ;
                idx_next = 10'(addr_reg);
                cnt_next = (COUNT_WIDTH > 32 && (ram_rdata >> 32) != '0) ? '1
                         : 32'(ram_rdata);
                state_next = ST_SQWT;
            end
            ST_SQWT:
            begin
                if (sq_done)
                begin
                    err_next = ((root >> 24) != '0) ? '1 : 24'(root);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            nb_cfg_reg <= 11'd1024;
            lo_reg     <= 32'sd0;
            hi_reg     <= 32'sd65536;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hbe_pkg::CFG_NUM_BINS:  nb_cfg_reg <= cfg_data[10:0];
                    hbe_pkg::CFG_LOW_EDGE:  lo_reg <= cfg_data;
                    hbe_pkg::CFG_HIGH_EDGE: hi_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        act_reg  <= act_next;
        kind_reg <= kind_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        err_reg  <= err_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign kind        = kind_reg;
    assign bin_index   = idx_reg;
    assign count       = cnt_reg;
    assign count_error = err_reg;

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count))
        else $error("result changed while stalled");
    a_no_ready_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ready)
        else $error("input taken during clear");
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == hbe_pkg::KIND_DROPPED || kind == hbe_pkg::KIND_BAD_BIN)
        |-> count == '0 && bin_index == '0)
        else $error("dropped result not zero");

endmodule

FILE: dv/tb_histogram_binning_engine.sv
// self-checking testbench for the histogram binning engine
`timescale 1ns / 1ps

module tb_histogram_binning_engine;

    localparam int MAX_BINS = 1024;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  bin_index;
        logic [31:0] count;
        logic [23:0] count_error;
    } bin_result_t;

    typedef struct {
        logic        action;
        logic [31:0] sample;
        logic [9:0]  read_bin;
        logic        has_fixed;
        bin_result_t fixed;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic signed [31:0] sample = '0;
    logic [9:0]  read_bin = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [9:0]  bin_index;
    logic [31:0] count;
    logic [23:0] count_error;

    // predictor state
    logic [31:0] bin_tally [MAX_BINS];
    logic [10:0] bins_cfg;
    logic signed [31:0] low_cfg;
    logic signed [31:0] high_cfg;

    bin_result_t expected_results[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    histogram_binning_engine i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .sample     (sample),
        .read_bin   (read_bin),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .bin_index  (bin_index),
        .count      (count),
        .count_error(count_error)
    );

    always #1 clk = ~clk;

    initial
    begin
        #4000000;
        $display("** histogram_binning_engine: FAILED **");
        $finish;
    end

    function automatic logic [23:0] sqrt_q8(input logic [31:0] c);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        begin
            v = {16'd0, c, 16'd0};
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            if (res > 64'hFFFFFF)
                res = 64'hFFFFFF;
            return res[23:0];
        end
    endfunction

    // works out the result of one item and updates the bin tally
    function automatic bin_result_t bin_item(input logic act, input logic [31:0] x,
                                             input logic [9:0] rb);
        bin_result_t r;
        longint nb;
        longint xs;
        longint lo;
        longint hi;
        longint b;
        begin
            r = '0;
            nb = (bins_cfg > MAX_BINS) ? MAX_BINS : bins_cfg;
            xs = longint'($signed(x));
            lo = longint'(low_cfg);
            hi = longint'(high_cfg);
            if (!act)
            begin
                if (nb == 0 || xs < lo || xs >= hi)
                    r.kind = hbe_pkg::KIND_DROPPED;
                else
                begin
                    b = (nb * (xs - lo)) / (hi - lo);
                    if (b >= nb)
                        b = nb - 1;
                    if (bin_tally[b] != 32'hFFFF_FFFF)
                        bin_tally[b] = bin_tally[b] + 1;
                    r.kind = hbe_pkg::KIND_COUNTED;
                    r.bin_index = b[9:0];
                    r.count = bin_tally[b];
                end
            end
            else if (longint'(rb) >= nb)
                r.kind = hbe_pkg::KIND_BAD_BIN;
            else
            begin
                r.kind = hbe_pkg::KIND_READ;
                r.bin_index = rb;
                r.count = bin_tally[rb];
                r.count_error = sqrt_q8(bin_tally[rb]);
            end
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            mismatches++;
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        end
    endtask

    // result side: random stalls and checking
    always @(posedge clk)
    begin
        bin_result_t e;
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected beat", {30'd0, kind}, 0);
            else
            begin
                e = expected_results.pop_front();
                if (kind != e.kind)
                    report_mismatch("kind", kind, e.kind);
                if (bin_index != e.bin_index)
                    report_mismatch("bin_index", bin_index, e.bin_index);
                if (count != e.count)
                    report_mismatch("count", count, e.count);
                if (count_error != e.count_error)
                    report_mismatch("count_error", count_error, e.count_error);
            end
        end
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid stays high after the beat until an idle cycle or drain lowers it or the next item replaces it
    task automatic send_item(input logic act, input logic [31:0] x, input logic [9:0] rb,
                             input logic has_fixed, input bin_result_t fixed);
        bin_result_t p;
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            action <= act;
            sample <= x;
            read_bin <= rb;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            p = bin_item(act, x, rb);
            if (has_fixed && p != fixed)
                report_mismatch("predictor vs table", p[31:0], fixed[31:0]);
            expected_results.push_back(p);
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
            repeat (80) @(posedge clk);
        end
    endtask

    task automatic write_reg(input hbe_pkg::cfg_idx_t idx, input logic [31:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            case (idx)
                hbe_pkg::CFG_NUM_BINS:  bins_cfg = val[10:0];
                hbe_pkg::CFG_LOW_EDGE:  low_cfg = val;
                default:                high_cfg = val;
            endcase
            @(posedge clk);
        end
    endtask

    function automatic stim_row_t row(input logic act, input logic [31:0] x,
                                      input logic [9:0] rb, input logic hf,
                                      input logic [1:0] k, input logic [9:0] bi,
                                      input logic [31:0] c, input logic [23:0] ce);
        stim_row_t s;
        begin
            s.action = act;
            s.sample = x;
            s.read_bin = rb;
            s.has_fixed = hf;
            s.fixed = {k, bi, c, ce};
            return s;
        end
    endfunction

    // random item: a quarter are bin reads; samples mostly in range, some edges, some noise
    task automatic random_item();
        logic [31:0] x;
        longint span;
        begin
            span = longint'(high_cfg) - longint'(low_cfg);
            if ($urandom_range(3) == 0)
                send_item(1'b1, 0, $urandom_range(1023), 0, '0);
            else
            begin
                case ($urandom_range(9))
                    0: x = $urandom();
                    1: x = low_cfg;
                    2: x = high_cfg - 1;
                    3: x = high_cfg;
                    default:
                        if (span > 0)
                            x = low_cfg + 32'(longint'($urandom()) % span);
                        else
                            x = $urandom();
                endcase
                send_item(1'b0, x, $urandom_range(1023), 0, '0);
            end
        end
    endtask

    initial
    begin
        stim_row_t dir[$];
        int        ph;
        for (int i = 0; i < MAX_BINS; i++)
            bin_tally[i] = '0;
        bins_cfg = 11'd1024;
        low_cfg = 0;
        high_cfg = 32'sd65536;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // after reset: range [0,1) in 1024 bins
        dir.push_back(row(1, 0, 10'd0, 1, hbe_pkg::KIND_READ, 0, 0, 0));
        dir.push_back(row(1, 0, 10'd1023, 1, hbe_pkg::KIND_READ, 10'd1023, 0, 0));
        dir.push_back(row(0, 32'h0, 0, 1, hbe_pkg::KIND_COUNTED, 0, 1, 0));
        dir.push_back(row(0, 32'h0000_FFFF, 0, 1, hbe_pkg::KIND_COUNTED, 10'd1023, 1, 0));
        dir.push_back(row(0, 32'h0001_0000, 0, 1, hbe_pkg::KIND_DROPPED, 0, 0, 0));
        dir.push_back(row(0, 32'hFFFF_FFFF, 0, 1, hbe_pkg::KIND_DROPPED, 0, 0, 0));
        dir.push_back(row(0, 32'h8000_0000, 0, 1, hbe_pkg::KIND_DROPPED, 0, 0, 0));
        dir.push_back(row(0, 32'h7FFF_FFFF, 0, 1, hbe_pkg::KIND_DROPPED, 0, 0, 0));
        dir.push_back(row(0, 32'h0000_0040, 0, 1, hbe_pkg::KIND_COUNTED, 10'd1, 1, 0));
        dir.push_back(row(0, 32'h0000_0000, 0, 1, hbe_pkg::KIND_COUNTED, 0, 2, 0));
        dir.push_back(row(0, 32'h0000_0000, 0, 1, hbe_pkg::KIND_COUNTED, 0, 3, 0));
        dir.push_back(row(0, 32'h0000_0000, 0, 1, hbe_pkg::KIND_COUNTED, 0, 4, 0));
        dir.push_back(row(1, 0, 10'd0, 1, hbe_pkg::KIND_READ, 0, 4, 24'd512));
        dir.push_back(row(1, 0, 10'd1, 1, hbe_pkg::KIND_READ, 10'd1, 1, 24'd256));
        dir.push_back(row(0, 32'h0000_8000, 0, 0, 0, 0, 0, 0));
        dir.push_back(row(1, 0, 10'd512, 0, 0, 0, 0, 0));
        foreach (dir[i])
            send_item(dir[i].action, dir[i].sample, dir[i].read_bin,
                      dir[i].has_fixed, dir[i].fixed);
        drain();

        // zero bins: everything dropped or flagged
        write_reg(hbe_pkg::CFG_NUM_BINS, 32'd0);
        send_item(0, 32'h0000_1000, 0, 1, {hbe_pkg::KIND_DROPPED, 10'd0, 32'd0, 24'd0});
        send_item(1, 0, 10'd0, 1, {hbe_pkg::KIND_BAD_BIN, 10'd0, 32'd0, 24'd0});
        drain();
        // bin count above the store size, full signed range
        write_reg(hbe_pkg::CFG_NUM_BINS, 32'h7FF);
        write_reg(hbe_pkg::CFG_LOW_EDGE, 32'h8000_0000);
        write_reg(hbe_pkg::CFG_HIGH_EDGE, 32'h7FFF_FFFF);
        send_item(0, 32'h8000_0000, 0, 0, '0);
        send_item(0, 32'h7FFF_FFFE, 0, 0, '0);
        send_item(0, 32'h7FFF_FFFF, 0, 1, {hbe_pkg::KIND_DROPPED, 10'd0, 32'd0, 24'd0});
        drain();
        // inverted range
        write_reg(hbe_pkg::CFG_LOW_EDGE, 32'h0001_0000);
        write_reg(hbe_pkg::CFG_HIGH_EDGE, 32'hFFFF_0000);
        send_item(0, 32'h0000_0000, 0, 1, {hbe_pkg::KIND_DROPPED, 10'd0, 32'd0, 24'd0});
        drain();

        // random phases under a range of settings
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            case (ph)
                0: begin write_reg(hbe_pkg::CFG_NUM_BINS, 1);
                         write_reg(hbe_pkg::CFG_LOW_EDGE, 32'hFFFF_0000);
                         write_reg(hbe_pkg::CFG_HIGH_EDGE, 32'h0001_0000); end
                1: begin write_reg(hbe_pkg::CFG_NUM_BINS, 7);
                         write_reg(hbe_pkg::CFG_LOW_EDGE, 32'hFFFF_FF00);
                         write_reg(hbe_pkg::CFG_HIGH_EDGE, 32'h0000_0300); end
                2: begin write_reg(hbe_pkg::CFG_NUM_BINS, 1024);
                         write_reg(hbe_pkg::CFG_LOW_EDGE, 32'h8000_0000);
                         write_reg(hbe_pkg::CFG_HIGH_EDGE, 32'h7FFF_FFFF); end
                3: begin write_reg(hbe_pkg::CFG_NUM_BINS, 1000);
                         write_reg(hbe_pkg::CFG_LOW_EDGE, 0);
                         write_reg(hbe_pkg::CFG_HIGH_EDGE, 32'h0000_0400); end
                4: begin write_reg(hbe_pkg::CFG_NUM_BINS, 2);
                         write_reg(hbe_pkg::CFG_LOW_EDGE, 32'h0000_0005);
                         write_reg(hbe_pkg::CFG_HIGH_EDGE, 32'h0000_0006); end
                5: begin write_reg(hbe_pkg::CFG_NUM_BINS, 300);
                         write_reg(hbe_pkg::CFG_LOW_EDGE, 32'hF000_0000);
                         write_reg(hbe_pkg::CFG_HIGH_EDGE, 32'h1000_0000); end
                6: begin write_reg(hbe_pkg::CFG_NUM_BINS, 1025);
                         write_reg(hbe_pkg::CFG_LOW_EDGE, 0);
                         write_reg(hbe_pkg::CFG_HIGH_EDGE, 32'h0010_0000); end
                default: begin write_reg(hbe_pkg::CFG_NUM_BINS, 16);
                         write_reg(hbe_pkg::CFG_LOW_EDGE, 0);
                         write_reg(hbe_pkg::CFG_HIGH_EDGE, 32'h0000_0010); end
            endcase
            repeat (235) random_item();
            drain();
        end

        if (mismatches == 0)
            $display("** histogram_binning_engine: PASSED **");
        else
            $display("** histogram_binning_engine: FAILED **");
        $finish;
    end

endmodule
